// ===== hw/rtl/rotation_matrix_to_quaternion_core_assert.svh =====
// assertion macros for the rotation matrix to quaternion core
// expects clk and rst_n in the scope of the including module
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH

// clocked property, off while in reset
`define RMQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rmq assertion failed");

// condition that must never hold
`define RMQ_ASSERT_NEVER(lbl, cond) \
    `RMQ_ASSERT(lbl, !(cond))

`endif

// ===== hw/rtl/rmq_pkg.sv =====
// types and constants of the rotation matrix to quaternion core
// used by every rtl module of the block, depends on nothing
`default_nettype none
package rmq_pkg;
    localparam int DATA_W = 32;
    localparam int FRAC_W = 28;
    localparam int RAD_W  = DATA_W + 2;
    localparam int SQV_W  = RAD_W + FRAC_W + 2;
    localparam int SQ_W   = (SQV_W + 1) / 2;
    localparam int SQR_W  = SQ_W + 3;
    localparam int DIFF_W = DATA_W + 1;
    localparam int NUM_W  = DIFF_W + FRAC_W;
    localparam int HI_W   = NUM_W - DATA_W;
    localparam int DR_W   = SQ_W + 1;

    localparam logic [1:0] PIV_W = 2'd0;
    localparam logic [1:0] PIV_X = 2'd1;
    localparam logic [1:0] PIV_Y = 2'd2;
    localparam logic [1:0] PIV_Z = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] r00;
        logic signed [DATA_W-1:0] r01;
        logic signed [DATA_W-1:0] r02;
        logic signed [DATA_W-1:0] r10;
        logic signed [DATA_W-1:0] r11;
        logic signed [DATA_W-1:0] r12;
        logic signed [DATA_W-1:0] r20;
        logic signed [DATA_W-1:0] r21;
        logic signed [DATA_W-1:0] r22;
    } mat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] qw;
        logic signed [DATA_W-1:0] qx;
        logic signed [DATA_W-1:0] qy;
        logic signed [DATA_W-1:0] qz;
        logic                     degenerate;
    } quat_t;

    typedef struct packed {
        logic [SQR_W-1:0]         rem;
        logic [SQ_W-1:0]          root;
        logic [SQV_W-1:0]         v;
        logic [1:0]               pivot;
        logic signed [DIFF_W-1:0] d0;
        logic signed [DIFF_W-1:0] d1;
        logic signed [DIFF_W-1:0] d2;
    } sq_t;

    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [DR_W-1:0]   rem;
        logic [DATA_W-1:0] q;
        logic [DATA_W-1:0] nlo;
    } lane_t;

    typedef struct packed {
        logic [SQ_W-1:0] root;
        logic [1:0]      pivot;
        lane_t [2:0]     lane;
    } dv_t;
endpackage
`default_nettype wire

// ===== hw/rtl/rmq_front.sv =====
// entry stage: trace, pivot choice, radicand and the three numerators
// depends on rmq_pkg
`default_nettype none
module rmq_front
    import rmq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire mat_t mat,
    output logic      valid,
    output sq_t       sq
);
    localparam int EW = DATA_W + 3;
    localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_W;

    logic signed [EW-1:0] e00, e11, e22, diag, rad;
    logic [RAD_W-1:0] radc;
    logic [1:0] pivot;
    logic signed [DIFF_W-1:0] dw_a, dw_b, dw_c, s01, s02, s12;
    logic valid_reg;
    sq_t sq_reg, sq_next;

    always_comb
    begin
        e00  = EW'(mat.r00);
        e11  = EW'(mat.r11);
        e22  = EW'(mat.r22);
        diag = e00 + e11 + e22;
        if (diag > 0)
        begin
            pivot = PIV_W;
            rad   = diag + ONE;
        end
        else if (e00 > e11 && e00 > e22)
        begin
            pivot = PIV_X;
            rad   = ONE + e00 - e11 - e22;
        end
        else if (e11 > e22)
        begin
            pivot = PIV_Y;
            rad   = ONE + e11 - e00 - e22;
        end
        else
        begin
            pivot = PIV_Z;
            rad   = ONE + e22 - e00 - e11;
        end
        radc = rad[EW-1] ? '0 : rad[RAD_W-1:0];

        dw_a = DIFF_W'(mat.r21) - DIFF_W'(mat.r12);
        dw_b = DIFF_W'(mat.r02) - DIFF_W'(mat.r20);
        dw_c = DIFF_W'(mat.r10) - DIFF_W'(mat.r01);
        s01  = DIFF_W'(mat.r01) + DIFF_W'(mat.r10);
        s02  = DIFF_W'(mat.r02) + DIFF_W'(mat.r20);
        s12  = DIFF_W'(mat.r12) + DIFF_W'(mat.r21);

        sq_next.rem   = '0;
        sq_next.root  = '0;
        sq_next.v     = {radc, {(FRAC_W + 2){1'b0}}};
        sq_next.pivot = pivot;
        unique case (pivot)
            PIV_W:
            begin
                sq_next.d0 = dw_a;
                sq_next.d1 = dw_b;
                sq_next.d2 = dw_c;
            end
            PIV_X:
            begin
                sq_next.d0 = dw_a;
                sq_next.d1 = s01;
                sq_next.d2 = s02;
            end
            PIV_Y:
            begin
                sq_next.d0 = dw_b;
                sq_next.d1 = s01;
                sq_next.d2 = s12;
            end
            default:
            begin
                sq_next.d0 = dw_c;
                sq_next.d1 = s02;
                sq_next.d2 = s12;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign valid = valid_reg;
    assign sq    = sq_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/rmq_sqrt_cell.sv =====
// one square root cell: settles one root bit and passes the item on
// depends on rmq_pkg
`default_nettype none
module rmq_sqrt_cell
    import rmq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic valid_in,
    input  wire sq_t  sq_in,
    output logic      valid_out,
    output sq_t       sq_out
);
    logic [SQR_W-1:0] rem_t, trial;
    logic valid_reg;
    sq_t sq_reg, sq_next;

    always_comb
    begin
        rem_t   = {sq_in.rem[SQR_W-3:0], sq_in.v[SQV_W-1 -: 2]};
        trial   = {1'b0, sq_in.root, 2'b01};
        sq_next = sq_in;
        sq_next.v = {sq_in.v[SQV_W-3:0], 2'b00};
        if (rem_t >= trial)
        begin
            sq_next.rem  = rem_t - trial;
            sq_next.root = {sq_in.root[SQ_W-2:0], 1'b1};
        end
        else
        begin
            sq_next.rem  = rem_t;
            sq_next.root = {sq_in.root[SQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign valid_out = valid_reg;
    assign sq_out    = sq_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/rmq_div_cell.sv =====
// one divider cell: settles one quotient bit in each of three lanes
// depends on rmq_pkg
`default_nettype none
module rmq_div_cell
    import rmq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic valid_in,
    input  wire dv_t  dv_in,
    output logic      valid_out,
    output dv_t       dv_out
);
    logic [DR_W-1:0] rem_t [3];
    logic [DR_W-1:0] dvs;
    logic valid_reg;
    dv_t dv_reg, dv_next;

    always_comb
    begin
        dv_next = dv_in;
        dvs     = {1'b0, dv_in.root};
        for (int i = 0; i < 3; i++)
        begin
            rem_t[i] = {dv_in.lane[i].rem[DR_W-2:0], dv_in.lane[i].nlo[DATA_W-1]};
            dv_next.lane[i].nlo = {dv_in.lane[i].nlo[DATA_W-2:0], 1'b0};
            if (rem_t[i] >= dvs)
            begin
                dv_next.lane[i].rem = rem_t[i] - dvs;
                dv_next.lane[i].q   = {dv_in.lane[i].q[DATA_W-2:0], 1'b1};
            end
            else
            begin
                dv_next.lane[i].rem = rem_t[i];
                dv_next.lane[i].q   = {dv_in.lane[i].q[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg <= dv_next;
    end

    assign valid_out = valid_reg;
    assign dv_out    = dv_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion_core.sv =====
// top level: rotation matrix to quaternion, pivoted four-branch method
// depends on rmq_pkg, rmq_front, rmq_sqrt_cell, rmq_div_cell and the assert header
//
//  port group        dir  handshake
//  mat               in   beat taken when start and not busy
//  quat              out  beat valid for the one cycle done is high
//
// one matrix per cycle, busy is always low
// pipeline: entry stage, 32 root cells, divider setup, 32 divider cells, output
// the root chain settles one bit per cell, the divider chain one bit per lane per cell
// reset clears every valid bit at once, no sweep
// done cannot be held off, each result shows for exactly one cycle
`default_nettype none
`include "rotation_matrix_to_quaternion_core_assert.svh"
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire mat_t  mat,
    output logic       done,
    output quat_t      quat
);
    localparam int LAT = SQ_W + DATA_W + 3;

    logic sq_valid [SQ_W+1];
    sq_t  sq_stage [SQ_W+1];
    logic dv_valid [DATA_W+1];
    dv_t  dv_stage [DATA_W+1];

    logic done_reg;
    quat_t quat_reg, quat_next;
    logic dv0_valid_reg;
    dv_t dv0_reg, dv0_next;

    logic signed [DIFF_W-1:0] dsel [3];
    logic [DIFF_W-1:0] mag [3];
    logic [NUM_W-1:0] num [3];
    logic [DATA_W-1:0] lim [3];
    logic [DATA_W-1:0] qs [3];
    logic [DATA_W-1:0] lres [3];
    logic [DATA_W-1:0] qtr;

    assign busy = 1'b0;

    rmq_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(start && !busy),
        .mat   (mat),
        .valid (sq_valid[0]),
        .sq    (sq_stage[0])
    );

    for (genvar k = 0; k < SQ_W; k++)
    begin : g_sqrt
        rmq_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_in (sq_valid[k]),
            .sq_in    (sq_stage[k]),
            .valid_out(sq_valid[k+1]),
            .sq_out   (sq_stage[k+1])
        );
    end

    always_comb
    begin
        dsel[0] = sq_stage[SQ_W].d0;
        dsel[1] = sq_stage[SQ_W].d1;
        dsel[2] = sq_stage[SQ_W].d2;
        dv0_next.root  = sq_stage[SQ_W].root;
        dv0_next.pivot = sq_stage[SQ_W].pivot;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = dsel[i][DIFF_W-1] ? (~dsel[i] + 1'b1) : dsel[i];
            num[i] = {mag[i], {FRAC_W{1'b0}}};
            dv0_next.lane[i].neg = dsel[i][DIFF_W-1];
            dv0_next.lane[i].ovf = DR_W'(num[i][NUM_W-1 -: HI_W])
                                   >= DR_W'(sq_stage[SQ_W].root);
            dv0_next.lane[i].rem = dv0_next.lane[i].ovf ? '0
                                   : DR_W'(num[i][NUM_W-1 -: HI_W]);
            dv0_next.lane[i].q   = '0;
            dv0_next.lane[i].nlo = num[i][DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv0_valid_reg <= 1'b0;
        end
        else
        begin
            dv0_valid_reg <= sq_valid[SQ_W];
        end
    end

    always_ff @(posedge clk)
    begin
        dv0_reg <= dv0_next;
    end

    assign dv_valid[0] = dv0_valid_reg;
    assign dv_stage[0] = dv0_reg;

    for (genvar k = 0; k < DATA_W; k++)
    begin : g_div
        rmq_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_in (dv_valid[k]),
            .dv_in    (dv_stage[k]),
            .valid_out(dv_valid[k+1]),
            .dv_out   (dv_stage[k+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lim[i] = dv_stage[DATA_W].lane[i].neg ? {1'b1, {(DATA_W-1){1'b0}}}
                                                  : {1'b0, {(DATA_W-1){1'b1}}};
            qs[i]  = (dv_stage[DATA_W].lane[i].ovf || dv_stage[DATA_W].lane[i].q > lim[i])
                     ? lim[i] : dv_stage[DATA_W].lane[i].q;
            lres[i] = dv_stage[DATA_W].lane[i].neg ? (~qs[i] + 1'b1) : qs[i];
        end
        qtr = DATA_W'(dv_stage[DATA_W].root >> 2);
        quat_next.degenerate = (dv_stage[DATA_W].root == '0);
        unique case (dv_stage[DATA_W].pivot)
            PIV_W:
            begin
                quat_next.qw = qtr;
                quat_next.qx = lres[0];
                quat_next.qy = lres[1];
                quat_next.qz = lres[2];
            end
            PIV_X:
            begin
                quat_next.qw = lres[0];
                quat_next.qx = qtr;
                quat_next.qy = lres[1];
                quat_next.qz = lres[2];
            end
            PIV_Y:
            begin
                quat_next.qw = lres[0];
                quat_next.qx = lres[1];
                quat_next.qy = qtr;
                quat_next.qz = lres[2];
            end
            default:
            begin
                quat_next.qw = lres[0];
                quat_next.qx = lres[1];
                quat_next.qy = lres[2];
                quat_next.qz = qtr;
            end
        endcase
        if (quat_next.degenerate)
        begin
            quat_next.qw = '0;
            quat_next.qx = '0;
            quat_next.qy = '0;
            quat_next.qz = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid[DATA_W];
        end
    end

    always_ff @(posedge clk)
    begin
        quat_reg <= quat_next;
    end

    assign done = done_reg;
    assign quat = quat_reg;

    `RMQ_ASSERT(a_latency, (start && !busy) |-> ##LAT done)
    `RMQ_ASSERT(a_no_ghost, done |-> $past(start, LAT))
    `RMQ_ASSERT(a_degen_zero, (done && quat.degenerate)
        |-> ({quat.qw, quat.qx, quat.qy, quat.qz} == '0))
    `RMQ_ASSERT_NEVER(a_never_busy, busy)
endmodule
`default_nettype wire

// ===== sim/tb_rotation_matrix_to_quaternion_core.sv =====
// self-checking testbench of rotation_matrix_to_quaternion_core
// depends on rmq_pkg and the core; predicts each quaternion in place and checks every result
`timescale 1ns / 100ps
module tb_rotation_matrix_to_quaternion_core;
    import rmq_pkg::*;

    localparam int  CYCLE_LIMIT = 200000;
    localparam int  LATENCY     = 67;
    localparam longint ONE_Q    = 64'sd1 << FRAC_W;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    mat_t  mat;
    logic  done;
    quat_t quat;

    quat_t quat_due[$];
    int    idle_pct;
    int    mismatches;
    int    beats_in;
    int    beats_out;
    int    degen_seen;
    int    cyc;

    rotation_matrix_to_quaternion_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .mat   (mat),
        .done  (done),
        .quat  (quat)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [127:0] root_of(logic [127:0] v);
        logic [127:0] res;
        logic [127:0] b;
        res = '0;
        b = 128'd1 << 126;
        while (b != 0 && b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] quot_sat(longint num, logic [127:0] den);
        logic         neg;
        logic [127:0] mag;
        logic [127:0] qq;
        logic [127:0] lim;
        neg = num < 0;
        mag = neg ? 128'(-num) : 128'(num);
        qq  = (mag << FRAC_W) / den;
        lim = neg ? (128'd1 << (DATA_W - 1)) : ((128'd1 << (DATA_W - 1)) - 1);
        if (qq > lim)
            qq = lim;
        return neg ? -qq[DATA_W-1:0] : qq[DATA_W-1:0];
    endfunction

    function automatic quat_t quat_from_mat(mat_t m);
        longint            a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint            tr, rad;
        logic [1:0]        piv;
        logic [127:0]      s2;
        logic [127:0]      qtr;
        logic [DATA_W-1:0] c[4];
        quat_t             q;
        a00 = m.r00; a01 = m.r01; a02 = m.r02;
        a10 = m.r10; a11 = m.r11; a12 = m.r12;
        a20 = m.r20; a21 = m.r21; a22 = m.r22;
        tr = a00 + a11 + a22;
        if (tr > 0)
        begin
            piv = PIV_W;
            rad = tr + ONE_Q;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            piv = PIV_X;
            rad = ONE_Q + a00 - a11 - a22;
        end
        else if (a11 > a22)
        begin
            piv = PIV_Y;
            rad = ONE_Q + a11 - a00 - a22;
        end
        else
        begin
            piv = PIV_Z;
            rad = ONE_Q + a22 - a00 - a11;
        end
        if (rad < 0)
            rad = 0;
        s2 = root_of(128'(rad) << (FRAC_W + 2));
        q = '0;
        if (s2 == 0)
        begin
            q.degenerate = 1'b1;
            return q;
        end
        case (piv)
            PIV_W:
            begin
                c[1] = quot_sat(a21 - a12, s2);
                c[2] = quot_sat(a02 - a20, s2);
                c[3] = quot_sat(a10 - a01, s2);
            end
            PIV_X:
            begin
                c[0] = quot_sat(a21 - a12, s2);
                c[2] = quot_sat(a01 + a10, s2);
                c[3] = quot_sat(a02 + a20, s2);
            end
            PIV_Y:
            begin
                c[0] = quot_sat(a02 - a20, s2);
                c[1] = quot_sat(a01 + a10, s2);
                c[3] = quot_sat(a12 + a21, s2);
            end
            default:
            begin
                c[0] = quot_sat(a10 - a01, s2);
                c[1] = quot_sat(a02 + a20, s2);
                c[2] = quot_sat(a12 + a21, s2);
            end
        endcase
        qtr = s2 >> 2;
        if (qtr > (128'd1 << (DATA_W - 1)) - 1)
            qtr = (128'd1 << (DATA_W - 1)) - 1;
        c[piv] = qtr[DATA_W-1:0];
        q.qw = c[0];
        q.qx = c[1];
        q.qy = c[2];
        q.qz = c[3];
        return q;
    endfunction

    // one beat; start stays high unless a gap follows
    task automatic send_mat(mat_t m);
        int gap;
        mat   <= m;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        quat_due.push_back(quat_from_mat(m));
        beats_in++;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            mat   <= mat_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom});
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (quat_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] to_q(real v);
        return DATA_W'($rtoi(v * 268435456.0));
    endfunction

    function automatic real rnd_unit();
        return $urandom_range(0, 2000000) / 1000000.0 - 1.0;
    endfunction

    function automatic mat_t rot_mat(real w, real x, real y, real z);
        real  n;
        mat_t m;
        n = $sqrt(w * w + x * x + y * y + z * z);
        if (n < 1.0e-6)
        begin
            w = 1.0;
            n = 1.0;
        end
        w = w / n; x = x / n; y = y / n; z = z / n;
        m.r00 = to_q(1.0 - 2.0 * (y * y + z * z));
        m.r01 = to_q(2.0 * (x * y - w * z));
        m.r02 = to_q(2.0 * (x * z + w * y));
        m.r10 = to_q(2.0 * (x * y + w * z));
        m.r11 = to_q(1.0 - 2.0 * (x * x + z * z));
        m.r12 = to_q(2.0 * (y * z - w * x));
        m.r20 = to_q(2.0 * (x * z - w * y));
        m.r21 = to_q(2.0 * (y * z + w * x));
        m.r22 = to_q(1.0 - 2.0 * (x * x + y * y));
        return m;
    endfunction

    function automatic mat_t rand_mat();
        mat_t m;
        int   kind;
        kind = $urandom_range(0, 9);
        m = rot_mat(rnd_unit(), rnd_unit(), rnd_unit(), rnd_unit());
        if (kind == 7)
            m = mat_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom});
        else if (kind == 8)
            m = m ^ mat_t'({$urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255)});
        else if (kind == 9)
        begin
            m.r00 = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            m.r11 = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            m.r22 = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            m.r01 = $urandom;
            m.r10 = $urandom;
        end
        return m;
    endfunction

    task automatic test_directed();
        mat_t m;
        idle_pct = 0;
        send_mat(rot_mat(1.0, 0.0, 0.0, 0.0));
        send_mat(rot_mat(0.0, 1.0, 0.0, 0.0));
        send_mat(rot_mat(0.0, 0.0, 1.0, 0.0));
        send_mat(rot_mat(0.0, 0.0, 0.0, 1.0));
        send_mat(rot_mat(0.1, 0.9, 0.3, -0.2));
        send_mat(rot_mat(-0.1, 0.2, -0.9, 0.3));
        send_mat(rot_mat(0.05, -0.3, 0.2, 0.9));
        send_mat(rot_mat(0.7, -0.7, 0.1, 0.1));
        send_mat('0);
        send_mat({9{32'h7fffffff}});
        send_mat({9{32'h80000000}});
        send_mat({9{32'hffffffff}});
        m = {9{32'h80000000}};
        m.r00 = 32'h7fffffff;
        send_mat(m);
        m = '0;
        m.r00 = -32'sd1;
        m.r11 = -32'sd1;
        m.r22 = -32'sd1;
        send_mat(m);
        m = {9{32'h7fffffff}};
        m.r00 = 32'h80000000;
        m.r11 = 32'h80000000;
        m.r22 = 32'h40000000;
        send_mat(m);
        m = {32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
             32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
        send_mat(m);
        m = '0;
        m.r00 = DATA_W'(-ONE_Q);
        m.r11 = DATA_W'(-ONE_Q);
        m.r22 = 32'sd0;
        send_mat(m);
        m = '0;
        m.r11 = 32'sd5;
        m.r22 = 32'sd5;
        m.r00 = -32'sd10;
        send_mat(m);
        m = '0;
        m.r12 = 32'h7fffffff;
        m.r21 = 32'h7fffffff;
        m.r00 = 32'h80000000;
        send_mat(m);
        pause_until_drained();
    endtask

    task automatic test_random(int pct, int count);
        idle_pct = pct;
        repeat (count) send_mat(rand_mat());
        pause_until_drained();
    endtask

    always @(posedge clk)
    begin
        quat_t exp_q;
        if (rst_n && done)
        begin
            beats_out++;
            if (quat.degenerate)
                degen_seen++;
            if (quat_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", quat);
            end
            else
            begin
                exp_q = quat_due.pop_front();
                if (quat.qw !== exp_q.qw || quat.qx !== exp_q.qx || quat.qy !== exp_q.qy ||
                    quat.qz !== exp_q.qz || quat.degenerate !== exp_q.degenerate)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %h %h %b, got %h %h %h %h %b",
                                 exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.degenerate,
                                 quat.qw, quat.qx, quat.qy, quat.qz, quat.degenerate);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cyc);
            $display("rotation_matrix_to_quaternion_core verification failed");
            $finish;
        end
    end

    initial
    begin
        cyc        = 0;
        mismatches = 0;
        beats_in   = 0;
        beats_out  = 0;
        degen_seen = 0;
        idle_pct   = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        mat        = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(0, 200);
        test_random(76, 200);
        test_random(14, 150);
        test_random(0, 100);
        start <= 1'b0;
        repeat (LATENCY + 10) @(posedge clk);
        if (quat_due.size() != 0)
            mismatches++;
        $display("%0d matrices sent, %0d quaternions checked, %0d degenerate",
                 beats_in, beats_out, degen_seen);
        $display("rotations on all pivots, extremes, noise and random bits, idle 0/76/14 pct");
        if (mismatches == 0)
            $display("rotation_matrix_to_quaternion_core verification clean");
        else
            $display("rotation_matrix_to_quaternion_core verification failed");
        $finish;
    end
endmodule
